/* rtl/core/dominant_pitch_color_core_macros.svh */
// assertion shorthands used by the checker file
`ifndef DOMINANT_PITCH_COLOR_CORE_MACROS_SVH
`define DOMINANT_PITCH_COLOR_CORE_MACROS_SVH

// clocked property, masked while reset is high
`define DPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked across reset
`define DPC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dpc_pkg.sv */
`default_nettype none

package dpc_pkg;

   localparam int BIN_W      = 11;
   localparam int MAXBIN_W   = 12;
   localparam int OFFSET_W   = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int COLOR_W    = 8;
   localparam int LOG_W      = 20;   // log2 in Q16, integer part up to 10
   localparam int MANT_W     = 31;   // normalised mantissa, Q30
   localparam int STEP_W     = 4;    // fraction bit counter
   localparam int RSP_BITS   = BIN_W + 3 * COLOR_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_BIN     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_BIN     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEREO      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOTE_OFFSET = 2'd3;

   typedef struct packed {
      logic [BIN_W-1:0]           min_bin;
      logic [MAXBIN_W-1:0]        max_bin;
      logic                       stereo;
      logic signed [OFFSET_W-1:0] note_offset;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOG,
      BK_PITCH,
      BK_MOD,
      BK_COLOR
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/dpc_front.sv */
`default_nettype none

module dpc_front #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dpc_pkg::cfg_type            cfg,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [dpc_pkg::BIN_W-1:0]   in_bin,
   input  wire logic signed [SAMPLE_WIDTH-1:0] in_lr,
   input  wire logic signed [SAMPLE_WIDTH-1:0] in_li,
   input  wire logic signed [SAMPLE_WIDTH-1:0] in_rr,
   input  wire logic signed [SAMPLE_WIDTH-1:0] in_ri,
   input  wire logic                        in_last,
   input  wire logic                        q_full,
   output logic                             push,
   output logic [dpc_pkg::BIN_W-1:0]        push_bin
);
   import dpc_pkg::*;

   localparam int PW = 2 * SAMPLE_WIDTH;

   logic                 s1_valid_ff, s1_last_ff, s1_range_ff;
   logic [BIN_W-1:0]     s1_bin_ff;
   logic [PW-1:0]        s1_ll_ff, s1_li_ff, s1_rl_ff, s1_ri_ff;
   logic signed [PW-1:0] sq_ll, sq_li, sq_rl, sq_ri;
   logic                 range_in;

   logic                 s2_valid_ff, s2_last_ff, s2_range_ff;
   logic [BIN_W-1:0]     s2_bin_ff;
   logic [PW-1:0]        s2_pow_ff, s2_pow_in, pow_l, pow_r;

   logic [PW-1:0]        best_power_ff;
   logic [BIN_W-1:0]     best_index_ff;
   logic                 adv, upd;

   assign adv      = !(s2_valid_ff && s2_last_ff && q_full);
   assign in_ready = adv;

   // stage 1: squares
   assign sq_ll    = in_lr * in_lr;
   assign sq_li    = in_li * in_li;
   assign sq_rl    = in_rr * in_rr;
   assign sq_ri    = in_ri * in_ri;
   assign range_in = (in_bin >= cfg.min_bin) && ({1'b0, in_bin} < cfg.max_bin);

   // stage 2: channel powers, louder one kept in stereo, left in mono
   assign pow_l     = s1_ll_ff + s1_li_ff;
   assign pow_r     = s1_rl_ff + s1_ri_ff;
   assign s2_pow_in = (cfg.stereo && (pow_r > pow_l)) ? pow_r : pow_l;

   // peak tracking at the end of the pipe
   assign upd      = s2_valid_ff && s2_range_ff && (s2_pow_ff > best_power_ff);
   assign push     = adv && s2_valid_ff && s2_last_ff;
   assign push_bin = upd ? s2_bin_ff :
                     ((best_power_ff == '0) ? cfg.min_bin : best_index_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff  <= in_last;
         s1_range_ff <= range_in;
         s1_bin_ff   <= in_bin;
         s1_ll_ff    <= sq_ll;
         s1_li_ff    <= sq_li;
         s1_rl_ff    <= sq_rl;
         s1_ri_ff    <= sq_ri;
         s2_last_ff  <= s1_last_ff;
         s2_range_ff <= s1_range_ff;
         s2_bin_ff   <= s1_bin_ff;
         s2_pow_ff   <= s2_pow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_power_ff <= '0;
      end else if (adv && s2_valid_ff) begin
         if (s2_last_ff) begin
            best_power_ff <= '0;
         end else if (upd) begin
            best_power_ff <= s2_pow_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && upd) begin
         best_index_ff <= s2_bin_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dpc_queue.sv */
`default_nettype none

module dpc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [dpc_pkg::BIN_W-1:0] push_bin,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           q_valid,
   output logic [dpc_pkg::BIN_W-1:0]      q_bin
);
   import dpc_pkg::*;

   logic [BIN_W-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_bin   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dpc_back.sv */
`default_nettype none

module dpc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dpc_pkg::cfg_type          cfg,
   input  wire logic                      q_valid,
   input  wire logic [dpc_pkg::BIN_W-1:0] q_bin,
   output logic                           pop,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [dpc_pkg::RSP_DATA_W-1:0] out_data
);
   import dpc_pkg::*;

   back_state_type       state_ff, state_in;
   logic                 load_out;

   logic [BIN_W-1:0]     bin_ff;
   logic [MANT_W-1:0]    m_ff;
   logic [LOG_W-1:0]     r_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic signed [17:0]   pitch_ff;
   logic [11:0]          s_ff;
   logic                 out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   // normalisation of the popped bin
   logic [3:0]           e;
   logic [40:0]          m_wide;
   // one squaring step
   logic [61:0]          prod;
   logic [31:0]          sq;
   // pitch
   logic [23:0]          r12;
   logic [15:0]          p12;
   logic signed [17:0]   pitch_in;
   // modulo 3072 as (pitch >> 10) mod 3, low bits kept
   logic [7:0]           v3;
   logic [3:0]           dsum;
   logic [2:0]           bsum;
   logic [1:0]           rem3;
   // colour
   logic [10:0]          x_r, x_g, x_b, x_m;
   logic [COLOR_W-1:0]   c_r, c_g, c_b;

   function automatic logic [10:0] saw_period(input logic [11:0] s,
                                              input logic [11:0] k);
      logic signed [12:0] v;
      logic [11:0]        m;
      logic [11:0]        n;
      begin
         v = $signed({1'b0, s}) - $signed({1'b0, k});
         m = (v < 0) ? 12'(v + 13'sd3072) : 12'(v);
         n = 12'd3072 - m;
         saw_period = (m < n) ? m[10:0] : n[10:0];
      end
   endfunction

   function automatic logic [10:0] saw_third(input logic [11:0] s);
      logic [11:0] v;
      logic [10:0] m;
      logic [10:0] n;
      begin
         v = s - 12'd512;
         m = {1'b0, v[9:0]};
         n = 11'd1024 - m;
         saw_third = (m < n) ? m : n;
      end
   endfunction

   function automatic logic [COLOR_W-1:0] to_byte(input logic [10:0] x,
                                                  input logic [10:0] mn);
      logic signed [11:0] d;
      logic signed [21:0] t;
      begin
         d = $signed({1'b0, x}) - $signed({1'b0, mn});
         t = ($signed(22'(d)) <<< 8) - 22'(d) + 22'sd512;
         if (t < 0) begin
            to_byte = '0;
         end else if (t[21:10] > 12'd255) begin
            to_byte = '1;
         end else begin
            to_byte = t[17:10];
         end
      end
   endfunction

   always_comb begin
      e = 4'd0;
      for (int i = 1; i < BIN_W; i++) begin
         if (q_bin[i]) e = 4'(i);
      end
   end
   assign m_wide = {q_bin, 30'b0} >> e;

   assign prod = m_ff * m_ff;
   assign sq   = prod[61:30];

   assign r12      = ({4'b0, r_ff} << 3) + ({4'b0, r_ff} << 2) + 24'd128;
   assign p12      = r12[23:8];
   assign pitch_in = $signed({2'b0, p12}) + 18'(cfg.note_offset);

   assign v3   = 8'(pitch_ff >>> 10) + 8'd96;
   assign dsum = 4'(v3[1:0]) + 4'(v3[3:2]) + 4'(v3[5:4]) + 4'(v3[7:6]);
   assign bsum = 3'(dsum[1:0]) + 3'(dsum[3:2]);
   always_comb begin
      priority if (bsum >= 3'd6) begin
         rem3 = 2'(bsum - 3'd6);
      end else if (bsum >= 3'd3) begin
         rem3 = 2'(bsum - 3'd3);
      end else begin
         rem3 = bsum[1:0];
      end
   end

   assign x_r = saw_period(s_ff, 12'd1536);
   assign x_g = saw_period(s_ff, 12'd2560);
   assign x_b = saw_period(s_ff, 12'd512);
   assign x_m = saw_third(s_ff);
   assign c_r = to_byte(x_r, x_m);
   assign c_g = to_byte(x_g, x_m);
   assign c_b = to_byte(x_b, x_m);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (q_valid) state_in = BK_LOG;
         BK_LOG:   if (cnt_ff == '0) state_in = BK_PITCH;
         BK_PITCH: state_in = BK_MOD;
         BK_MOD:   state_in = BK_COLOR;
         BK_COLOR: if (!out_valid_ff || out_ready) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE:  pop = q_valid;
         BK_COLOR: load_out = !out_valid_ff || out_ready;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            bin_ff <= q_bin;
            m_ff   <= m_wide[MANT_W-1:0];
            r_ff   <= {e, 16'b0};
            cnt_ff <= '1;
         end
         BK_LOG: begin
            if (sq[31]) begin
               r_ff <= r_ff | (LOG_W'(1) << cnt_ff);
               m_ff <= sq[31:1];
            end else begin
               m_ff <= sq[30:0];
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
         BK_PITCH: pitch_ff <= pitch_in;
         BK_MOD:   s_ff <= {rem3, pitch_ff[9:0]};
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= RSP_DATA_W'({c_b, c_g, c_r, bin_ff});
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

/* rtl/core/dominant_pitch_color_core.sv */
// Dominant pitch colour core.
// req_*: one FFT bin word per cycle while req_tready is high, left and right
//   complex values plus the bin number; req_tlast marks the last bin of a
//   frame. Bins in [min_bin, max_bin) are searched for the first strict
//   maximum of |X|^2 (louder channel in stereo, left only in mono).
// rsp_*: one word per frame, the peak bin and its 8-bit RGB pitch colour.
// csr_*: register writes, index 0 min_bin, 1 max_bin, 2 stereo, 3 note_offset;
//   write only while no frame is in flight.
// Throughput: one bin per cycle while req_tready is high. The colour unit
//   handles one frame at a time, using a bit-serial log2 (16 squaring steps
//   on a 31x31 multiplier); a two-entry queue holds finished frames meanwhile.
// rsp_tvalid rises when the colour unit has finished the frame's peak bin.
// Reset clears the pipeline, the queue, the peak tracker and the registers
//   to their defaults (min_bin 1, max_bin 2048, stereo, note_offset -1843).
// rsp_tready low holds the result word; the colour unit then holds one more
//   frame and the queue two, after which the next frame end waits in the
//   tracker and req_tready drops.
`default_nettype none

module dominant_pitch_color_core #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // bin_index, left_real, left_imag, right_real, right_imag, zero pad
   input  wire logic [((dpc_pkg::BIN_W + 4*SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]
                                                       req_tdata,
   input  wire logic                                   req_tlast,  // frame_end
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // peak_bin, red, green, blue, zero pad
   output logic [dpc_pkg::RSP_DATA_W-1:0]              rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [dpc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [dpc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import dpc_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   cfg_type          cfg_ff;
   logic             q_full, push, pop, q_valid;
   logic [BIN_W-1:0] push_bin, q_bin;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bin     <= BIN_W'(1);
         cfg_ff.max_bin     <= MAXBIN_W'(2048);
         cfg_ff.stereo      <= 1'b1;
         cfg_ff.note_offset <= -16'sd1843;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_BIN:     cfg_ff.min_bin     <= csr_wdata[BIN_W-1:0];
            CSR_MAX_BIN:     cfg_ff.max_bin     <= csr_wdata[MAXBIN_W-1:0];
            CSR_STEREO:      cfg_ff.stereo      <= csr_wdata[0];
            CSR_NOTE_OFFSET: cfg_ff.note_offset <= $signed(csr_wdata);
            default:         ;
         endcase
      end
   end

   // front: squares, channel select, peak tracking
   dpc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_bin   (req_tdata[BIN_W-1:0]),
      .in_lr    ($signed(req_tdata[BIN_W +   SW - 1 -: SW])),
      .in_li    ($signed(req_tdata[BIN_W + 2*SW - 1 -: SW])),
      .in_rr    ($signed(req_tdata[BIN_W + 3*SW - 1 -: SW])),
      .in_ri    ($signed(req_tdata[BIN_W + 4*SW - 1 -: SW])),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .push     (push),
      .push_bin (push_bin)
   );

   // peak bins of finished frames
   dpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_bin (push_bin),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_bin    (q_bin)
   );

   // back: log2, pitch, colour, result register
   dpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_bin     (q_bin),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/dpc_checker.sv */
`default_nettype none
`include "dominant_pitch_color_core_macros.svh"

module dpc_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_tready,
   input wire logic                                   rsp_tvalid,
   input wire logic                                   rsp_tready,
   input wire logic [dpc_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import dpc_pkg::*;

   logic [RSP_DATA_W-1:0] pad_mask;
   assign pad_mask = ~(RSP_DATA_W'({RSP_BITS{1'b1}}));

   // a stalled result word must hold
   `DPC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word dropped or changed under stall")

   // no result straight after reset
   `DPC_ASSERT_NR(a_rsp_reset, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")

   // input side open straight after reset
   `DPC_ASSERT_NR(a_req_reset, clock, reset |=> req_tready, "req_tready low after reset")

   // padding above the colour bytes stays zero
   `DPC_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> (rsp_tdata & pad_mask) == '0, "rsp pad bits set")

endmodule

bind dominant_pitch_color_core dpc_checker u_dpc_checker (.*);

`default_nettype wire
